// ----- hdl/toeq_pkg.sv -----
package toeq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int TICK_W   = 64;
  localparam int TAG_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TICK_W-1:0] tick;
  } entry_t;

endpackage

// ----- hdl/tick_ordered_event_queue_core.sv -----
// Channel  Dir  tdata                                   tuser
// in_      in   [63:0] event_tick, [95:64] event_tag    [0] command
// out_     out  [63:0] popped_tick, [95:64] popped_tag,  [0] popped_valid,
//               [100:96] entry_count, [103:101] zero     [2:1] status
//
// One transaction in flight at a time. Pop: head read, then result. Pop on empty,
// insert into an empty or full queue: result from idle. Other inserts: each event
// with a later tick moves up one slot, then the new one is written; the memory
// read/compare/write loop moves one entry per cycle. rst_n is synchronous, active
// low; the store needs no clearing pass. A result waits in the output register
// while out_tready is low; the next transaction is taken once it drains.
module tick_ordered_event_queue_core
  import toeq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // [63:0] event_tick, [95:64] event_tag
  input  logic         in_tuser,   // [0] command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [63:0] tick, [95:64] tag, [100:96] entry_count
  output logic [2:0]   out_tuser   // [0] popped_valid, [2:1] status
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_PLACE = 2'd3;

  // logical offset from head to physical address, circular over QUEUE_DEPTH
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) sum = sum - (CW+1)'(QUEUE_DEPTH);
    return sum[AW-1:0];
  endfunction

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  entry_t            new_r, new_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              o_pv_r, o_pv_nxt;
  logic [TICK_W-1:0] o_tick_r, o_tick_nxt;
  logic [TAG_W-1:0]  o_tag_r, o_tag_nxt;
  logic [STATUS_W-1:0] o_status_r, o_status_nxt;
  logic [COUNT_W-1:0]  o_count_r, o_count_nxt;

  entry_t            mem [QUEUE_DEPTH];
  entry_t            rd_r;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  entry_t            mem_wd;

  logic              in_acc;
  entry_t            in_entry;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign in_entry  = '{tag: in_tdata[95:64], tick: in_tdata[63:0]};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    pos_nxt       = pos_r;
    new_nxt       = new_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_pv_nxt      = o_pv_r;
    o_tick_nxt    = o_tick_r;
    o_tag_nxt     = o_tag_r;
    o_status_nxt  = o_status_r;
    o_count_nxt   = o_count_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = new_r;
    mem_re        = 1'b0;
    mem_ra        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          new_nxt    = in_entry;
          o_pv_nxt   = 1'b0;
          o_tick_nxt = '0;
          o_tag_nxt  = '0;
          if (in_tuser == CMD_INSERT) begin
            if (count_r == CW'(QUEUE_DEPTH)) begin
              out_valid_nxt = 1'b1;
              o_status_nxt  = STATUS_FULL;
              o_count_nxt   = COUNT_W'(count_r);
            end else if (count_r == '0) begin
              mem_we        = 1'b1;
              mem_wa        = head_r;
              mem_wd        = in_entry;
              count_nxt     = CW'(1);
              out_valid_nxt = 1'b1;
              o_status_nxt  = STATUS_OK;
              o_count_nxt   = COUNT_W'(1);
            end else begin
              mem_re    = 1'b1;
              mem_ra    = phys(head_r, count_r - CW'(1));
              pos_nxt   = count_r;
              state_nxt = S_SCAN;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              o_status_nxt  = STATUS_EMPTY;
              o_count_nxt   = '0;
            end else begin
              mem_re    = 1'b1;
              mem_ra    = head_r;
              state_nxt = S_POP;
            end
          end
        end
      end
      S_POP: begin
        head_nxt      = phys(head_r, CW'(1));
        count_nxt     = count_r - CW'(1);
        out_valid_nxt = 1'b1;
        o_pv_nxt      = 1'b1;
        o_tick_nxt    = rd_r.tick;
        o_tag_nxt     = rd_r.tag;
        o_status_nxt  = STATUS_OK;
        o_count_nxt   = COUNT_W'(count_r - CW'(1));
        state_nxt     = S_IDLE;
      end
      S_SCAN: begin
        mem_we = 1'b1;
        mem_wa = phys(head_r, pos_r);
        if (rd_r.tick > new_r.tick) begin
          // move the later entry up one slot, fetch the one below it if any
          mem_wd  = rd_r;
          pos_nxt = pos_r - CW'(1);
          if (pos_r == CW'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            mem_re = 1'b1;
            mem_ra = phys(head_r, pos_r - CW'(2));
          end
        end else begin
          mem_wd        = new_r;
          count_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          o_status_nxt  = STATUS_OK;
          o_count_nxt   = COUNT_W'(count_r + CW'(1));
          state_nxt     = S_IDLE;
        end
      end
      S_PLACE: begin
        mem_we        = 1'b1;
        mem_wa        = phys(head_r, pos_r);
        mem_wd        = new_r;
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        o_status_nxt  = STATUS_OK;
        o_count_nxt   = COUNT_W'(count_r + CW'(1));
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    new_r      <= new_nxt;
    o_pv_r     <= o_pv_nxt;
    o_tick_r   <= o_tick_nxt;
    o_tag_r    <= o_tag_nxt;
    o_status_r <= o_status_nxt;
    o_count_r  <= o_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, o_count_r, o_tag_r, o_tick_r};
  assign out_tuser  = {o_status_r, o_pv_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !out_valid_r)
    else $error("result pending while a transaction is in progress");

  a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> (pos_r != '0) && (pos_r <= count_r))
    else $error("insert position out of range");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_pv_r |-> o_status_r == STATUS_OK)
    else $error("popped event with error status");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |=> count_r == $past(count_r) - CW'(1))
    else $error("pop did not decrement occupancy");

endmodule

// ----- tb/sv/tb_tick_ordered_event_queue_core.sv -----
module tb_tick_ordered_event_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import toeq_pkg::*;

  localparam int QUEUE_DEPTH  = DEFAULT_QUEUE_DEPTH;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = QUEUE_DEPTH + 20;
  localparam int MAX_REPORTS  = 60;

  typedef struct packed {
    logic                popped_valid;
    logic [TICK_W-1:0]   tick;
    logic [TAG_W-1:0]    tag;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } pop_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;   // [63:0] event_tick, [95:64] event_tag
  logic         in_tuser = CMD_INSERT;  // [0] command
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [103:0] out_tdata;       // [63:0] tick, [95:64] tag, [100:96] entry_count
  logic [2:0]   out_tuser;       // [0] popped_valid, [2:1] status

  entry_t      event_store[$];
  pop_result_t expected_results[$];
  int          fail_count = 0;
  int          ready_hold = 0;
  bit          no_idle = 1'b0;

  tick_ordered_event_queue_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sorted insert behind equal ticks, pop from the head.
  task automatic queue_predict(input logic cmd, input logic [TICK_W-1:0] tick,
                               input logic [TAG_W-1:0] tag);
    pop_result_t r;
    entry_t      e;
    int          pos;
    r = '0;
    if (cmd == CMD_INSERT) begin
      if (event_store.size() >= QUEUE_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos = event_store.size();
        while (pos > 0 && event_store[pos-1].tick > tick) pos--;
        e.tick = tick;
        e.tag  = tag;
        event_store.insert(pos, e);
        r.status = STATUS_OK;
      end
    end else if (event_store.size() == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      e = event_store.pop_front();
      r.popped_valid = 1'b1;
      r.tick         = e.tick;
      r.tag          = e.tag;
      r.status       = STATUS_OK;
    end
    r.count = COUNT_W'(event_store.size());
    expected_results.push_back(r);
  endtask

  task automatic send_event(input logic cmd, input logic [TICK_W-1:0] tick,
                            input logic [TAG_W-1:0] tag);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {tag, tick};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    queue_predict(cmd, tick, tag);
  endtask

  function automatic void check_field(string name, logic [63:0] exp_val,
                                      logic [63:0] act_val);
    if (exp_val !== act_val) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name,
                 exp_val, act_val);
    end
  endfunction

  task automatic check_result();
    pop_result_t exp_r;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: unexpected result, expected none actual tdata %0h tuser %0h",
                 $time, out_tdata, out_tuser);
    end else begin
      exp_r = expected_results.pop_front();
      check_field("popped_valid", exp_r.popped_valid, out_tuser[0]);
      check_field("status", exp_r.status, out_tuser[2:1]);
      check_field("popped_tick", exp_r.tick, out_tdata[63:0]);
      check_field("popped_tag", exp_r.tag, out_tdata[95:64]);
      check_field("entry_count", exp_r.count, out_tdata[100:96]);
      check_field("tdata pad", 64'd0, out_tdata[103:101]);
    end
  endtask

  // Result side: check each transaction, then hold out_tready low for a random stall (none while no_idle).
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_result();
      ready_hold = no_idle ? 0 : $urandom_range(0, 19);
    end else if (ready_hold > 0) begin
      ready_hold--;
    end
    out_tready <= (ready_hold == 0);
  end

  function automatic logic [TICK_W-1:0] draw_tick(input bit tie_heavy);
    logic [TICK_W-1:0] t;
    int                sel;
    sel = $urandom_range(0, 9);
    if (tie_heavy && sel < 7) begin
      t = TICK_W'($urandom_range(0, 5));
    end else begin
      case (sel)
        0: t = '0;
        1: t = '1;
        2: t = '1 - TICK_W'($urandom_range(0, 3));
        3, 4: t = TICK_W'($urandom_range(0, 15));
        default: t = {$urandom, $urandom};
      endcase
    end
    return t;
  endfunction

  task automatic test_pop_on_empty();
    send_event(CMD_POP, {$urandom, $urandom}, $urandom);
  endtask

  // Extreme ticks and tags, plus several events sharing a tick.
  task automatic test_extremes_and_ties();
    send_event(CMD_INSERT, '1, '1);
    send_event(CMD_INSERT, '0, '0);
    send_event(CMD_INSERT, 64'd5, 32'h0000_0001);
    send_event(CMD_INSERT, 64'd5, 32'h0000_0002);
    send_event(CMD_INSERT, 64'd5, 32'h0000_0003);
    send_event(CMD_INSERT, '0, 32'hA5A5_5A5A);
    send_event(CMD_POP, '0, '0);
    send_event(CMD_POP, '1, '1);
  endtask

  // Fill to capacity, then an insert that must be dropped even though its
  // tick is the smallest possible.
  task automatic test_full_drop();
    int i;
    for (i = 0; event_store.size() < QUEUE_DEPTH; i++)
      send_event(CMD_INSERT, i[0] ? '1 : TICK_W'(i % 5), 32'h1000_0000 + i);
    send_event(CMD_INSERT, '0, 32'hDEAD_BEEF);
    send_event(CMD_POP, '0, '0);
    send_event(CMD_POP, '0, '0);
  endtask

  // Phases with different insert/pop mixes so the queue swings between
  // empty and full; some phases run without any idle cycles.
  task automatic test_random_traffic();
    int  sent;
    int  phase_len;
    int  insert_pct;
    int  k;
    bit  tie_heavy;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 150);
      case ($urandom_range(0, 4))
        0: insert_pct = 90;
        1: insert_pct = 70;
        2: insert_pct = 50;
        3: insert_pct = 30;
        default: insert_pct = 10;
      endcase
      tie_heavy = $urandom_range(0, 1);
      no_idle   = ($urandom_range(0, 3) == 0);
      for (k = 0; k < phase_len; k++) begin
        if ($urandom_range(1, 100) <= insert_pct)
          send_event(CMD_INSERT, draw_tick(tie_heavy), $urandom);
        else
          send_event(CMD_POP, {$urandom, $urandom}, $urandom);
      end
      sent += phase_len;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_pop_on_empty();
    test_extremes_and_ties();
    test_full_drop();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/toeq_pkg.sv
hdl/tick_ordered_event_queue_core.sv
tb/sv/tb_tick_ordered_event_queue_core.sv
